[design/skt_pkg.sv]
// Shared types, constants and codes for the sorted key table.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int DEPTH       = 64;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int KEY_W       = 14;
    localparam int TAG_W       = 2;
    localparam int WT_W        = 4;
    localparam int SUM_W       = 10;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DROP   = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_LIST
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [WT_W-1:0]  wt;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic list_step;
    } ctrl_t;

    typedef struct packed {
        logic list_end;
    } stat_t;

endpackage

`default_nettype wire

[design/skt_ctrl.sv]
// Controller state machine for the sorted key table.
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [skt_pkg::OP_W-1:0] opcode,
    input  wire skt_pkg::stat_t           stat,
    output skt_pkg::ctrl_t                ctrl,
    output logic                          busy
);

    skt_pkg::state_t state_reg;
    skt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl.capture   = 1'b0;
        ctrl.apply     = 1'b0;
        ctrl.list_step = 1'b0;
        busy           = 1'b1;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    if (opcode == skt_pkg::OP_LIST)
                    begin
                        state_next = skt_pkg::S_LIST;
                    end
                    else
                    begin
                        state_next = skt_pkg::S_UPDATE;
                    end
                end
            end
            skt_pkg::S_UPDATE:
            begin
                ctrl.apply = 1'b1;
                state_next = skt_pkg::S_IDLE;
            end
            skt_pkg::S_LIST:
            begin
                ctrl.list_step = 1'b1;
                if (stat.list_end)
                begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/skt_datapath.sv]
// Datapath of the sorted key table: entry cells, count, weight sum and result register.
`timescale 1ns / 1ps
`default_nettype none

module skt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire skt_pkg::ctrl_t                ctrl,
    output skt_pkg::stat_t                     stat,
    input  wire logic [skt_pkg::OP_W-1:0]      opcode,
    input  wire logic [skt_pkg::TAG_W-1:0]     subject,
    input  wire logic [skt_pkg::KEY_W-1:0]     course_number,
    input  wire logic [skt_pkg::WT_W-1:0]      credits,
    output logic                               result_valid,
    output logic [skt_pkg::STATUS_W-1:0]       status,
    output logic                               entry_valid,
    output logic [skt_pkg::TAG_W-1:0]          entry_subject,
    output logic [skt_pkg::KEY_W-1:0]          entry_key,
    output logic [skt_pkg::WT_W-1:0]           entry_credits,
    output logic [skt_pkg::SUM_W-1:0]          total_credits,
    output logic                               last
);

    localparam int DEPTH = skt_pkg::DEPTH;
    localparam int CNT_W = skt_pkg::CNT_W;

    skt_pkg::entry_t cell_reg [DEPTH];
    skt_pkg::entry_t cell_next [DEPTH];

    logic [DEPTH-1:0] ge_reg;
    logic [DEPTH-1:0] eq_reg;
    logic [DEPTH-1:0] ge_next;
    logic [DEPTH-1:0] eq_next;
    logic [DEPTH-1:0] first_eq;

    logic [skt_pkg::OP_W-1:0] op_reg;
    skt_pkg::entry_t          new_reg;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [skt_pkg::SUM_W-1:0] sum_reg;
    logic [skt_pkg::SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         list_len;

    logic                     full;
    logic                     found;
    logic                     do_insert;
    logic                     do_drop;
    logic                     do_rotate;
    logic [skt_pkg::WT_W-1:0] drop_wt;

    logic                          res_valid_reg;
    logic [skt_pkg::STATUS_W-1:0]  res_status_reg;
    logic                          res_entry_valid_reg;
    skt_pkg::entry_t               res_entry_reg;
    logic [skt_pkg::SUM_W-1:0]     res_sum_reg;
    logic                          res_last_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign found     = |eq_reg;
    assign do_insert = ctrl.apply && (op_reg == skt_pkg::OP_INSERT) && !full;
    assign do_drop   = ctrl.apply && (op_reg == skt_pkg::OP_DROP) && found;
    assign do_rotate = ctrl.list_step && (count_reg != '0);
    assign list_len  = (int'(count_reg) > skt_pkg::MAX_RESULTS)
                       ? CNT_W'(skt_pkg::MAX_RESULTS) : count_reg;

    assign stat.list_end = (count_reg == '0) || ((idx_reg + CNT_W'(1)) == count_reg);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign ge_next[gi] = (CNT_W'(gi) >= count_reg) ||
                                 (cell_reg[gi].key >= course_number);
            assign eq_next[gi] = (CNT_W'(gi) < count_reg) &&
                                 (cell_reg[gi].key == course_number);

            if (gi == 0)
            begin : g_head
                assign first_eq[gi] = ge_reg[gi] && eq_reg[gi];
            end
            else
            begin : g_body
                assign first_eq[gi] = ge_reg[gi] && !ge_reg[gi-1] && eq_reg[gi];
            end

            always_comb
            begin
                cell_next[gi] = cell_reg[gi];
                if (do_insert && ge_reg[gi])
                begin
                    if (gi == 0)
                    begin
                        cell_next[gi] = new_reg;
                    end
                    else if (!ge_reg[(gi == 0) ? 0 : gi-1])
                    begin
                        cell_next[gi] = new_reg;
                    end
                    else
                    begin
                        cell_next[gi] = cell_reg[(gi == 0) ? 0 : gi-1];
                    end
                end
                else if (do_drop && ge_reg[gi] && (gi < DEPTH - 1))
                begin
                    cell_next[gi] = cell_reg[(gi < DEPTH - 1) ? gi+1 : gi];
                end
                else if (do_rotate)
                begin
                    if ((gi == DEPTH - 1) || (CNT_W'(gi) == count_reg - CNT_W'(1)))
                    begin
                        cell_next[gi] = cell_reg[0];
                    end
                    else
                    begin
                        cell_next[gi] = cell_reg[(gi < DEPTH - 1) ? gi+1 : gi];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                cell_reg[gi] <= cell_next[gi];
            end
        end
    endgenerate

    always_comb
    begin
        drop_wt = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            drop_wt = drop_wt | (first_eq[i] ? cell_reg[i].wt : '0);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + skt_pkg::SUM_W'(new_reg.wt);
        end
        else if (do_drop)
        begin
            count_next = count_reg - CNT_W'(1);
            sum_next   = sum_reg - skt_pkg::SUM_W'(drop_wt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            res_valid_reg <= ctrl.apply || (ctrl.list_step &&
                             ((count_reg == '0) || (int'(idx_reg) < skt_pkg::MAX_RESULTS)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            op_reg      <= opcode;
            new_reg.key <= course_number;
            new_reg.tag <= subject;
            new_reg.wt  <= credits;
            ge_reg      <= ge_next;
            eq_reg      <= eq_next;
            idx_reg     <= '0;
        end
        else if (do_rotate)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end

        if (ctrl.apply)
        begin
            res_entry_valid_reg <= 1'b0;
            res_entry_reg       <= '0;
            res_sum_reg         <= sum_next;
            res_last_reg        <= 1'b1;
            if ((op_reg == skt_pkg::OP_INSERT) && full)
            begin
                res_status_reg <= skt_pkg::ST_FULL;
            end
            else if ((op_reg == skt_pkg::OP_DROP) && !found)
            begin
                res_status_reg <= skt_pkg::ST_NOT_FOUND;
            end
            else
            begin
                res_status_reg <= skt_pkg::ST_OK;
            end
        end
        else if (ctrl.list_step)
        begin
            res_status_reg <= skt_pkg::ST_OK;
            res_sum_reg    <= sum_reg;
            if (count_reg == '0)
            begin
                res_entry_valid_reg <= 1'b0;
                res_entry_reg       <= '0;
                res_last_reg        <= 1'b1;
            end
            else
            begin
                res_entry_valid_reg <= 1'b1;
                res_entry_reg       <= cell_reg[0];
                res_last_reg        <= ((idx_reg + CNT_W'(1)) == list_len);
            end
        end
    end

    assign result_valid  = res_valid_reg;
    assign status        = res_status_reg;
    assign entry_valid   = res_entry_valid_reg;
    assign entry_subject = res_entry_reg.tag;
    assign entry_key     = res_entry_reg.key;
    assign entry_credits = res_entry_reg.wt;
    assign total_credits = res_sum_reg;
    assign last          = res_last_reg;

endmodule

`default_nettype wire

[design/sorted_key_table_with_sum.sv]
// Top level of the sorted key table with running weight sum.
// A command word is taken when start is high and busy is low. Insert, drop and unused
// opcodes pass a capture cycle that compares the key against every cell at once, and
// the following cycle shifts the cells and updates the count and weight sum for an
// insert or drop that takes effect; one result word follows. A list captures the
// command and then steps once per stored entry (once for an empty table), since the
// cells rotate past the head cell once per cycle. Each result word is shown for exactly
// one cycle with result_valid high and must be taken then, as the block cannot be
// stalled. The table is empty after reset with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_with_sum (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [skt_pkg::OP_W-1:0]      opcode,
    input  wire logic [skt_pkg::TAG_W-1:0]     subject,
    input  wire logic [skt_pkg::KEY_W-1:0]     course_number,
    input  wire logic [skt_pkg::WT_W-1:0]      credits,
    output logic                               result_valid,
    output logic [skt_pkg::STATUS_W-1:0]       status,
    output logic                               entry_valid,
    output logic [skt_pkg::TAG_W-1:0]          entry_subject,
    output logic [skt_pkg::KEY_W-1:0]          entry_key,
    output logic [skt_pkg::WT_W-1:0]           entry_credits,
    output logic [skt_pkg::SUM_W-1:0]          total_credits,
    output logic                               last
);

    skt_pkg::ctrl_t ctrl;
    skt_pkg::stat_t stat;

    skt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    skt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .opcode        (opcode),
        .subject       (subject),
        .course_number (course_number),
        .credits       (credits),
        .result_valid  (result_valid),
        .status        (status),
        .entry_valid   (entry_valid),
        .entry_subject (entry_subject),
        .entry_key     (entry_key),
        .entry_credits (entry_credits),
        .total_credits (total_credits),
        .last          (last)
    );

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("Result word without a command in progress.");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("Block still busy after the final result word.");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted command did not raise busy.");

endmodule

`default_nettype wire
